[rtl/bpe_pkg.sv]
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants and types of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int STEPS       = 100;
  localparam int COORD_W     = 12;
  localparam int STEP_W      = 7;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // a*STEPS + (b-a)*k, signed
  localparam int NUM_W       = 22;
  // |num| never exceeds 2048*STEPS
  localparam int MAG_W       = 18;
  // divide by STEPS as multiply by rounded-up reciprocal
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'((2**RECIP_SHIFT + STEPS - 1) / STEPS);

  localparam int LERP_STAGES = 3;
  localparam int LEVELS      = 3;
  localparam int PIPE_DEPTH  = LEVELS * LERP_STAGES;
  localparam int K_DEPTH     = (LEVELS - 1) * LERP_STAGES;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_X0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_Y0 = CFG_IDX_W'(4);

  typedef struct packed {
    logic [LERP_STAGES-1:0] en;
    logic [STEP_W-1:0]      k;
  } level_ctl_t;

endpackage

[rtl/cubic_bezier_point_eval_unit.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_unit
// Cubic Bezier point evaluator, de Casteljau with integer interpolation.
//
// Load the four x and four y control points through the cfg channel
// (index 0..3: x0..x3, 4..7: y0..y3; low 12 bits kept, higher indexes
// dropped). Write them only while the pipeline is empty.
// Each in_ item carries a step index k; t = k/100, k above 100 reads as 100.
// Each item returns one out_ item with the point's x and y.
// Each item passes nine register stages (three levels of interpolation,
// three stages each: multiply-add, reciprocal multiply, shift and sign).
// Throughput: one item per cycle while the receiver does not stall.
// Reset clears the control points to zero and empties the pipeline.
// When the receiver stalls, items hold in place while empty stages ahead
// of them still fill, so in_tready drops only once the pipeline is full.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bpe_pkg::IN_TDATA_W-1:0]      in_tdata,   // [6:0] step_index
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bpe_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [11:0] point_x, [23:12] point_y
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic signed [bpe_pkg::COORD_W-1:0] ctrl_r [bpe_pkg::NUM_REGS];

  bpe_pkg::level_ctl_t                level_ctl [bpe_pkg::LEVELS];
  logic [bpe_pkg::PIPE_DEPTH-1:0]     vld;

  logic signed [bpe_pkg::COORD_W-1:0] lv0_x [3];
  logic signed [bpe_pkg::COORD_W-1:0] lv0_y [3];
  logic signed [bpe_pkg::COORD_W-1:0] lv1_x [2];
  logic signed [bpe_pkg::COORD_W-1:0] lv1_y [2];
  logic signed [bpe_pkg::COORD_W-1:0] lv2_x;
  logic signed [bpe_pkg::COORD_W-1:0] lv2_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bpe_pkg::NUM_REGS; i++) begin
        ctrl_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < bpe_pkg::CFG_IDX_W'(bpe_pkg::NUM_REGS))) begin
      ctrl_r[cfg_index[2:0]] <= signed'(cfg_data[bpe_pkg::COORD_W-1:0]);
    end
  end

  bpe_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_step   (in_tdata[bpe_pkg::STEP_W-1:0]),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .level_ctl (level_ctl),
    .vld       (vld)
  );

  for (genvar j = 0; j < 3; j++) begin : g_lv0
    bpe_lerp u_x (
      .clk (clk),
      .ctl (level_ctl[0]),
      .a   (ctrl_r[bpe_pkg::REG_CTRL_X0 + j]),
      .b   (ctrl_r[bpe_pkg::REG_CTRL_X0 + j + 1]),
      .res (lv0_x[j])
    );
    bpe_lerp u_y (
      .clk (clk),
      .ctl (level_ctl[0]),
      .a   (ctrl_r[bpe_pkg::REG_CTRL_Y0 + j]),
      .b   (ctrl_r[bpe_pkg::REG_CTRL_Y0 + j + 1]),
      .res (lv0_y[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_lv1
    bpe_lerp u_x (
      .clk (clk),
      .ctl (level_ctl[1]),
      .a   (lv0_x[j]),
      .b   (lv0_x[j+1]),
      .res (lv1_x[j])
    );
    bpe_lerp u_y (
      .clk (clk),
      .ctl (level_ctl[1]),
      .a   (lv0_y[j]),
      .b   (lv0_y[j+1]),
      .res (lv1_y[j])
    );
  end

  bpe_lerp u_lv2_x (
    .clk (clk),
    .ctl (level_ctl[2]),
    .a   (lv1_x[0]),
    .b   (lv1_x[1]),
    .res (lv2_x)
  );

  bpe_lerp u_lv2_y (
    .clk (clk),
    .ctl (level_ctl[2]),
    .a   (lv1_y[0]),
    .b   (lv1_y[1]),
    .res (lv2_y)
  );

  assign out_tdata = {lv2_y, lv2_x};

  a_idle_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline empty at the tail but input not ready");

  a_item_count : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !(in_tvalid && in_tready) && !(out_tvalid && out_tready))
      |=> $countones(vld) == $past($countones(vld)))
    else $error("item lost or duplicated inside the pipeline");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && (vld == '1)) |-> !in_tready)
    else $error("input taken while the pipeline is full and stalled");

endmodule

[rtl/bpe_lerp.sv]
// ----------------------------------------------------------------------------
// bpe_lerp
// One integer interpolation trunc((a*STEPS + (b-a)*k) / STEPS), three stages.
// ----------------------------------------------------------------------------
module bpe_lerp (
  input  logic                                clk,
  input  bpe_pkg::level_ctl_t                 ctl,
  input  logic signed [bpe_pkg::COORD_W-1:0]  a,
  input  logic signed [bpe_pkg::COORD_W-1:0]  b,
  output logic signed [bpe_pkg::COORD_W-1:0]  res
);

  logic signed [bpe_pkg::COORD_W:0]   diff;
  logic signed [bpe_pkg::STEP_W:0]    k_s;
  logic signed [bpe_pkg::NUM_W-1:0]   num_nxt, num_r;
  logic signed [bpe_pkg::NUM_W-1:0]   mag_full;
  logic [bpe_pkg::MAG_W-1:0]          mag;
  logic [bpe_pkg::PROD_W-1:0]         prod_nxt, prod_r;
  logic                               neg_r;
  logic [bpe_pkg::COORD_W:0]          quo;
  logic [bpe_pkg::COORD_W-1:0]        res_nxt, res_r;

  always_comb begin
    diff    = (bpe_pkg::COORD_W+1)'(b) - (bpe_pkg::COORD_W+1)'(a);
    k_s     = signed'({1'b0, ctl.k});
    num_nxt = bpe_pkg::NUM_W'(a) * bpe_pkg::NUM_W'(bpe_pkg::STEPS)
            + bpe_pkg::NUM_W'(diff) * bpe_pkg::NUM_W'(k_s);
  end

  always_comb begin
    mag_full = num_r[bpe_pkg::NUM_W-1] ? -num_r : num_r;
    mag      = mag_full[bpe_pkg::MAG_W-1:0];
    prod_nxt = bpe_pkg::PROD_W'(mag) * bpe_pkg::PROD_W'(bpe_pkg::RECIP_MUL);
  end

  always_comb begin
    quo     = {1'b0, prod_r[bpe_pkg::RECIP_SHIFT +: bpe_pkg::COORD_W]};
    res_nxt = neg_r ? bpe_pkg::COORD_W'((bpe_pkg::COORD_W+1)'(0) - quo)
                    : quo[bpe_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      num_r <= num_nxt;
    end
    if (ctl.en[1]) begin
      prod_r <= prod_nxt;
      neg_r  <= num_r[bpe_pkg::NUM_W-1];
    end
    if (ctl.en[2]) begin
      res_r <= res_nxt;
    end
  end

  assign res = signed'(res_r);

endmodule

[rtl/bpe_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// bpe_pipe_ctrl
// Valid bits, per-stage load enables and the step index delay line.
// ----------------------------------------------------------------------------
module bpe_pipe_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [bpe_pkg::STEP_W-1:0]         in_step,
  input  logic                               out_ready,
  output logic                               in_ready,
  output logic                               out_valid,
  output bpe_pkg::level_ctl_t                level_ctl [bpe_pkg::LEVELS],
  output logic [bpe_pkg::PIPE_DEPTH-1:0]     vld
);

  logic [bpe_pkg::PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic [bpe_pkg::PIPE_DEPTH-1:0] en;
  logic [bpe_pkg::STEP_W-1:0]     k_clamp;
  logic [bpe_pkg::STEP_W-1:0]     k_r [bpe_pkg::K_DEPTH];

  // saturate past the curve end
  assign k_clamp = (in_step > bpe_pkg::STEP_W'(bpe_pkg::STEPS)) ?
                   bpe_pkg::STEP_W'(bpe_pkg::STEPS) : in_step;

  always_comb begin
    en[bpe_pkg::PIPE_DEPTH-1] = !vld_r[bpe_pkg::PIPE_DEPTH-1] || out_ready;
    for (int i = bpe_pkg::PIPE_DEPTH-2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < bpe_pkg::PIPE_DEPTH; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k_r[0] <= k_clamp;
    end
    for (int i = 1; i < bpe_pkg::K_DEPTH; i++) begin
      if (en[i]) begin
        k_r[i] <= k_r[i-1];
      end
    end
  end

  always_comb begin
    level_ctl[0].en = en[0 +: bpe_pkg::LERP_STAGES];
    level_ctl[0].k  = k_clamp;
    for (int l = 1; l < bpe_pkg::LEVELS; l++) begin
      level_ctl[l].en = en[l*bpe_pkg::LERP_STAGES +: bpe_pkg::LERP_STAGES];
      level_ctl[l].k  = k_r[l*bpe_pkg::LERP_STAGES - 1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[bpe_pkg::PIPE_DEPTH-1];
  assign vld       = vld_r;

endmodule
